### rtl/core/pf_pkg.sv
// Shared constants, types and the prime table for the trial-division factorizer.
`default_nettype none
package pf_pkg;

    // Field widths
    localparam int VALUE_BITS  = 16;
    localparam int PRIME_BITS  = VALUE_BITS / 2;
    localparam int EXP_BITS    = 4;
    localparam int PRIME_COUNT = 54;
    localparam int MAX_FACTORS = 6;
    localparam int IDX_BITS    = $clog2(PRIME_COUNT + 1);
    localparam int CNT_BITS    = $clog2(MAX_FACTORS + 1);
    localparam int SLOT_BITS   = $clog2(MAX_FACTORS);
    localparam int DCNT_BITS   = $clog2(VALUE_BITS + 1);

    localparam logic [EXP_BITS-1:0]  EXP_MAX   = '1;
    localparam logic [IDX_BITS-1:0]  IDX_LIMIT = IDX_BITS'(PRIME_COUNT);
    localparam logic [CNT_BITS-1:0]  CNT_MAX   = CNT_BITS'(MAX_FACTORS);

    // Request to the serial divider
    typedef struct packed {
        logic                    start;
        logic [VALUE_BITS-1:0]   dividend;
        logic [PRIME_BITS-1:0]   divisor;
    } t_div_req;

    // Answer from the serial divider
    typedef struct packed {
        logic                    done;
        logic [VALUE_BITS-1:0]   quotient;
        logic                    rem_zero;
    } t_div_rsp;

    // Factor pairs and end-of-item marker from the sequencer
    typedef struct packed {
        logic                    wr;
        logic [VALUE_BITS-1:0]   prime;
        logic [EXP_BITS-1:0]     exponent;
        logic                    done;
    } t_fact_evt;

    // Primes below 2^8, ascending
    function automatic logic [PRIME_BITS-1:0] prime_at(input logic [IDX_BITS-1:0] idx);
        logic [PRIME_BITS-1:0] p;
        case (idx)
            6'd0:  p = 8'd2;    6'd1:  p = 8'd3;    6'd2:  p = 8'd5;    6'd3:  p = 8'd7;
            6'd4:  p = 8'd11;   6'd5:  p = 8'd13;   6'd6:  p = 8'd17;   6'd7:  p = 8'd19;
            6'd8:  p = 8'd23;   6'd9:  p = 8'd29;   6'd10: p = 8'd31;   6'd11: p = 8'd37;
            6'd12: p = 8'd41;   6'd13: p = 8'd43;   6'd14: p = 8'd47;   6'd15: p = 8'd53;
            6'd16: p = 8'd59;   6'd17: p = 8'd61;   6'd18: p = 8'd67;   6'd19: p = 8'd71;
            6'd20: p = 8'd73;   6'd21: p = 8'd79;   6'd22: p = 8'd83;   6'd23: p = 8'd89;
            6'd24: p = 8'd97;   6'd25: p = 8'd101;  6'd26: p = 8'd103;  6'd27: p = 8'd107;
            6'd28: p = 8'd109;  6'd29: p = 8'd113;  6'd30: p = 8'd127;  6'd31: p = 8'd131;
            6'd32: p = 8'd137;  6'd33: p = 8'd139;  6'd34: p = 8'd149;  6'd35: p = 8'd151;
            6'd36: p = 8'd157;  6'd37: p = 8'd163;  6'd38: p = 8'd167;  6'd39: p = 8'd173;
            6'd40: p = 8'd179;  6'd41: p = 8'd181;  6'd42: p = 8'd191;  6'd43: p = 8'd193;
            6'd44: p = 8'd197;  6'd45: p = 8'd199;  6'd46: p = 8'd211;  6'd47: p = 8'd223;
            6'd48: p = 8'd227;  6'd49: p = 8'd229;  6'd50: p = 8'd233;  6'd51: p = 8'd239;
            6'd52: p = 8'd241;  6'd53: p = 8'd251;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

### rtl/core/pf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module pf_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pf_pkg::t_div_req i_req,
    output pf_pkg::t_div_rsp      o_rsp
);
    import pf_pkg::*;

    logic [VALUE_BITS-1:0] r_q,    n_q;
    logic [PRIME_BITS-1:0] r_r,    n_r;
    logic [PRIME_BITS-1:0] r_d;
    logic [DCNT_BITS-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [PRIME_BITS:0]   trial;
    logic                  qbit;

    // One shift-subtract step
    always_comb begin
        trial = {r_r, r_q[VALUE_BITS-1]};
        qbit  = (trial >= {1'b0, r_d});
        n_r   = qbit ? PRIME_BITS'(trial - {1'b0, r_d}) : trial[PRIME_BITS-1:0];
        n_q   = {r_q[VALUE_BITS-2:0], qbit};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_BITS'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
    assign o_rsp.rem_zero = (r_r == '0);

endmodule
`default_nettype wire

### rtl/core/pf_seq.sv
// Trial-division sequencer: walks the prime table and counts exponents.
`default_nettype none
module pf_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pf_pkg::VALUE_BITS-1:0] i_value,
    output pf_pkg::t_fact_evt                  o_evt
);
    import pf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [VALUE_BITS-1:0]   r_n,     n_n;
    logic [IDX_BITS-1:0]     r_idx,   n_idx;
    logic [EXP_BITS-1:0]     r_e,     n_e;
    logic [PRIME_BITS-1:0]   prime;
    logic [VALUE_BITS-1:0]   square;
    t_div_req                req;
    t_div_rsp                rsp;

    pf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    assign prime  = prime_at(r_idx);
    assign square = VALUE_BITS'(prime) * VALUE_BITS'(prime);

    // Next state and events
    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_idx        = r_idx;
        n_e          = r_e;
        req.start    = 1'b0;
        req.dividend = r_n;
        req.divisor  = prime;
        o_evt.wr       = 1'b0;
        o_evt.prime    = r_n;
        o_evt.exponent = EXP_BITS'(1);
        o_evt.done     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_value;
                    n_idx   = '0;
                    n_e     = '0;
                    n_state = (i_value > VALUE_BITS'(1)) ? S_CHECK : S_FIN;
                end
            end
            S_CHECK: begin
                if (r_idx == IDX_LIMIT || square > r_n) begin
                    // leftover above one is itself prime
                    o_evt.wr = (r_n > VALUE_BITS'(1));
                    n_state  = S_FIN;
                end else begin
                    req.start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (rsp.done) begin
                    if (rsp.rem_zero) begin
                        n_n          = rsp.quotient;
                        n_e          = (r_e == EXP_MAX) ? r_e : r_e + 1'b1;
                        req.start    = 1'b1;
                        req.dividend = rsp.quotient;
                    end else begin
                        o_evt.wr       = (r_e != '0);
                        o_evt.prime    = VALUE_BITS'(prime);
                        o_evt.exponent = r_e;
                        n_idx          = r_idx + 1'b1;
                        n_e            = '0;
                        n_state        = S_CHECK;
                    end
                end
            end
            S_FIN: begin
                o_evt.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_e     <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
    end

endmodule
`default_nettype wire

### rtl/core/prime_factorizer_top.sv
// Top level: input channel, factor buffer and output register of the factorizer.
//
// Input channel: i_valid / o_stall with i_value. An item is taken on a rising
// edge with i_valid high and o_stall low. Output channel: o_valid / i_stall
// with o_prime, o_exponent, o_last; a result moves when o_valid is high and
// i_stall is low.
// Each item yields one to six (prime, exponent) results, largest prime first,
// o_last set on the final one. Values 0 and 1 give one result (0, 0, last).
// Every trial division runs through the bit-serial divider, and the table walk
// stops once p*p exceeds the remaining value; the worst case is about 54
// divisions per item. Results then leave one per cycle while i_stall is low.
// o_stall stays high from acceptance until the last result sits in the output
// register, so the next item may enter while that result waits.
// A stalled result holds in the output register until taken.
// Reset (synchronous, active low) drops any item in flight and clears o_valid.
`default_nettype none
module prime_factorizer_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pf_pkg::VALUE_BITS-1:0] i_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pf_pkg::VALUE_BITS-1:0]      o_prime,
    output logic [pf_pkg::EXP_BITS-1:0]        o_exponent,
    output logic                               o_last
);
    import pf_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_FACT = 2'd1;
    localparam logic [1:0] T_OUT  = 2'd2;

    logic [1:0]            r_state;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [SLOT_BITS-1:0]  r_rd;
    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_prime;
    logic [EXP_BITS-1:0]   r_exp;
    logic                  r_last;
    logic [VALUE_BITS-1:0] mem_prime [MAX_FACTORS];
    logic [EXP_BITS-1:0]   mem_exp   [MAX_FACTORS];
    logic                  accept;
    logic                  load_ok;
    t_fact_evt             evt;

    assign o_stall = (r_state != T_IDLE);
    assign accept  = i_valid && !o_stall;
    assign load_ok = !r_valid || !i_stall;

    pf_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(accept),
        .i_value(i_value),
        .o_evt  (evt)
    );

    // Factor buffer, ascending prime order
    always_ff @(posedge i_clk) begin
        if (r_state == T_FACT && evt.wr && r_cnt < CNT_MAX) begin
            mem_prime[r_cnt[SLOT_BITS-1:0]] <= evt.prime;
            mem_exp[r_cnt[SLOT_BITS-1:0]]   <= evt.exponent;
        end
    end

    // Control: collect pairs, then drain the buffer from the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_valid <= 1'b0;
        end else begin
            // Output valid: set on each load, cleared once the result is taken
            if (r_state == T_OUT && load_ok) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_cnt   <= '0;
                        r_state <= T_FACT;
                    end
                end
                T_FACT: begin
                    if (evt.wr && r_cnt < CNT_MAX) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (evt.done) begin
                        r_rd    <= SLOT_BITS'(r_cnt - 1'b1);
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (load_ok) begin
                        if (r_cnt == '0 || r_rd == '0) begin
                            r_state <= T_IDLE;
                        end else begin
                            r_rd <= r_rd - 1'b1;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // Output register, loaded from the buffer, or with (0, 0, last) when it is empty
    always_ff @(posedge i_clk) begin
        if (r_state == T_OUT && load_ok) begin
            if (r_cnt == '0) begin
                r_prime <= '0;
                r_exp   <= '0;
                r_last  <= 1'b1;
            end else begin
                r_prime <= mem_prime[r_rd];
                r_exp   <= mem_exp[r_rd];
                r_last  <= (r_rd == '0);
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_prime    = r_prime;
    assign o_exponent = r_exp;
    assign o_last     = r_last;

endmodule
`default_nettype wire
